>>> rtl/core/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, constants and helpers of the addressable LED frame encoder.
// ----------------------------------------------------------------------------
package ale_pkg;

    // Bits sent per LED; colour bits beyond 24 are sent as zeros.
    localparam int COLOR_BITS = 24;
    localparam int BITPOS_W   = $clog2(COLOR_BITS);

    // Input queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW  = 3'd4;

    localparam logic [7:0]  RST_LED_COUNT  = 8'd8;
    localparam logic [15:0] RST_ZERO_HIGH  = 16'd18;
    localparam logic [15:0] RST_ONE_HIGH   = 16'd35;
    localparam logic [15:0] RST_BIT_PERIOD = 16'd63;
    localparam logic [15:0] RST_RESET_LOW  = 16'd4000;

    // Frame modes.
    localparam logic [1:0] MODE_SAME   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  mode;
        logic [23:0] color;
        logic [7:0]  lit_index;
    } t_item;

    typedef struct packed {
        logic [7:0]  led_count;
        logic [15:0] zero_high_ticks;
        logic [15:0] one_high_ticks;
        logic [15:0] bit_period_ticks;
        logic [15:0] reset_low_ticks;
    } t_cfg;

    // Wire order of a colour word: middle byte, upper byte, lower byte.
    function automatic logic [23:0] reorder(input logic [23:0] c);
        return {c[15:8], c[23:16], c[7:0]};
    endfunction

endpackage

>>> rtl/core/ale_front.sv
// ----------------------------------------------------------------------------
// ale_front
// Accepts input ticks, folds the unused mode code into the all-same mode and
// holds the ticks in a short queue for the frame sequencer.
// ----------------------------------------------------------------------------
module ale_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_start_req,
    input  logic [1:0]    i_mode,
    input  logic [23:0]   i_color,
    input  logic [7:0]    i_lit_index,
    output logic          o_item_valid,
    input  logic          i_item_pop,
    output ale_pkg::t_item o_item
);

    ale_pkg::t_item                 r_mem [ale_pkg::QUEUE_DEPTH];
    logic [ale_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ale_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ale_pkg::QCNT_W-1:0]     r_count, n_count;
    ale_pkg::t_item                 w_item;
    logic                           w_push;
    logic                           w_pop;

    localparam logic [ale_pkg::QPTR_W-1:0] LAST_PTR = ale_pkg::QPTR_W'(ale_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        w_item.start_req = i_start_req;
        w_item.mode      = (i_mode == ale_pkg::MODE_UNUSED) ? ale_pkg::MODE_SAME : i_mode;
        w_item.color     = i_color;
        w_item.lit_index = i_lit_index;
    end

    assign o_in_ready   = (r_count != ale_pkg::QCNT_W'(ale_pkg::QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = i_item_pop && o_item_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

>>> rtl/core/ale_back.sv
// ----------------------------------------------------------------------------
// ale_back
// Frame sequencer: advances the bit and latch timers by one tick per queued
// item and registers the line level and status flags for the output channel.
// ----------------------------------------------------------------------------
module ale_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ale_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    output logic           o_item_pop,
    input  ale_pkg::t_item i_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_line,
    output logic           o_busy_res,
    output logic           o_pixel_taken,
    output logic           o_done_res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BIT   = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    localparam int CB = ale_pkg::COLOR_BITS;
    localparam int BW = ale_pkg::BITPOS_W;

    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_mode, n_mode;
    logic [7:0]    r_led_pos, n_led_pos;
    logic [7:0]    r_target, n_target;
    logic [23:0]   r_held, n_held;
    logic [CB-1:0] r_shift, n_shift;
    logic [BW-1:0] r_bit_pos, n_bit_pos;
    logic [15:0]   r_tick, n_tick;

    logic          r_out_valid;
    logic          r_line, n_line;
    logic          r_busy, n_busy;
    logic          r_taken, n_taken;
    logic          r_done, n_done;

    logic          w_fire;
    logic          w_start;
    logic [16:0]   w_tick_inc;
    logic [BW:0]   w_bit_inc;
    logic [8:0]    w_led_inc;
    logic [15:0]   w_high;

    // Colour of one LED, left aligned in the shift register.
    function automatic logic [CB-1:0] pixel_for(input logic [1:0] mode,
                                                input logic [7:0] pos,
                                                input logic [7:0] target,
                                                input logic [23:0] held,
                                                input logic [23:0] color);
        logic [23:0] pix;
        pix = ale_pkg::reorder(held);
        if (mode == ale_pkg::MODE_STREAM) begin
            pix = ale_pkg::reorder(color);
        end else if (mode == ale_pkg::MODE_SINGLE && pos != target) begin
            pix = '0;
        end
        return CB'(pix) << (CB - 24);
    endfunction

    assign w_fire     = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_item_pop = w_fire;
    assign w_start    = (r_phase != PH_BIT) && (r_phase != PH_LATCH) && i_item.start_req;

    always_comb begin
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_led_pos = r_led_pos;
        n_target  = r_target;
        n_held    = r_held;
        n_shift   = r_shift;
        n_bit_pos = r_bit_pos;
        n_tick    = r_tick;
        n_line    = 1'b0;
        n_busy    = 1'b0;
        n_taken   = 1'b0;
        n_done    = 1'b0;

        // A start tick loads the frame and then runs as the first timed tick.
        if (r_phase != PH_BIT && r_phase != PH_LATCH) begin
            n_phase = PH_IDLE;
            if (w_start) begin
                n_mode    = i_item.mode;
                n_target  = i_item.lit_index;
                n_held    = i_item.color;
                n_led_pos = '0;
                n_bit_pos = '0;
                n_tick    = '0;
                n_busy    = 1'b1;
                if (i_cfg.led_count == '0) begin
                    n_phase = PH_LATCH;
                end else begin
                    n_shift = pixel_for(i_item.mode, 8'd0, i_item.lit_index, i_item.color,
                                        i_item.color);
                    n_taken = (i_item.mode == ale_pkg::MODE_STREAM);
                    n_phase = PH_BIT;
                end
            end
        end

        w_tick_inc = {1'b0, n_tick} + 17'd1;
        w_bit_inc  = {1'b0, n_bit_pos} + 1'b1;
        w_led_inc  = {1'b0, n_led_pos} + 9'd1;
        w_high     = n_shift[CB-1] ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;

        if (n_phase == PH_BIT) begin
            n_busy = 1'b1;
            n_line = (n_tick < w_high);
            if (w_tick_inc >= {1'b0, i_cfg.bit_period_ticks}) begin
                n_tick = '0;
                if (w_bit_inc >= (BW + 1)'(CB)) begin
                    n_bit_pos = '0;
                    if (w_led_inc >= {1'b0, i_cfg.led_count}) begin
                        n_phase = PH_LATCH;
                    end else begin
                        n_led_pos = w_led_inc[7:0];
                        n_shift   = pixel_for(n_mode, w_led_inc[7:0], n_target, n_held,
                                              i_item.color);
                        n_taken   = (n_mode == ale_pkg::MODE_STREAM);
                    end
                end else begin
                    n_bit_pos = w_bit_inc[BW-1:0];
                    n_shift   = {n_shift[CB-2:0], 1'b0};
                end
            end else begin
                n_tick = w_tick_inc[15:0];
            end
        end else if (n_phase == PH_LATCH) begin
            n_busy = 1'b1;
            if (w_tick_inc >= {1'b0, i_cfg.reset_low_ticks}) begin
                n_done  = 1'b1;
                n_tick  = '0;
                n_phase = PH_IDLE;
            end else begin
                n_tick = w_tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mode      <= '0;
            r_led_pos   <= '0;
            r_target    <= '0;
            r_held      <= '0;
            r_shift     <= '0;
            r_bit_pos   <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase   <= n_phase;
                r_mode    <= n_mode;
                r_led_pos <= n_led_pos;
                r_target  <= n_target;
                r_held    <= n_held;
                r_shift   <= n_shift;
                r_bit_pos <= n_bit_pos;
                r_tick    <= n_tick;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_line  <= n_line;
            r_busy  <= n_busy;
            r_taken <= n_taken;
            r_done  <= n_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line        = r_line;
    assign o_busy_res    = r_busy;
    assign o_pixel_taken = r_taken;
    assign o_done_res    = r_done;

    // The line is only driven high inside a frame.
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_line) |-> r_busy)
        else $error("line high outside a frame");

    // A pixel is only sampled from the input in the streaming mode.
    a_taken_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_taken) |-> (r_mode == ale_pkg::MODE_STREAM && r_phase == PH_BIT))
        else $error("pixel taken outside a streaming frame");

    // Completion leaves the sequencer idle and is reported as busy.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done && $past(w_fire)) |-> (r_busy && r_phase == PH_IDLE))
        else $error("done without returning to idle");

    // An item is never popped while a result is stalled.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_item_pop)
        else $error("item consumed while output stalled");

endmodule

>>> rtl/core/addressable_led_frame_encoder.sv
// ----------------------------------------------------------------------------
// A tick accepted at the input passes the input queue register, then the
// output register, before its result shows. Throughput: one tick per cycle
// unless the output stalls; the sequencer advances once per queued tick.
// Reset: synchronous, active low; clears the queue, the sequencer to idle and
// the configuration registers to their defaults (8 LEDs, 18/35/63, 4000).
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder
// One-wire RGB LED frame encoder with a configuration register file, an input
// queue and a frame sequencer.
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_start_req,
    input  logic [1:0]                       i_mode,
    input  logic [23:0]                      i_color,
    input  logic [7:0]                       i_lit_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_line,
    output logic                             o_busy_res,
    output logic                             o_pixel_taken,
    output logic                             o_done_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ale_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ale_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ale_pkg::t_cfg  r_cfg;
    ale_pkg::t_item w_item;
    logic           w_item_valid;
    logic           w_item_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count        <= ale_pkg::RST_LED_COUNT;
            r_cfg.zero_high_ticks  <= ale_pkg::RST_ZERO_HIGH;
            r_cfg.one_high_ticks   <= ale_pkg::RST_ONE_HIGH;
            r_cfg.bit_period_ticks <= ale_pkg::RST_BIT_PERIOD;
            r_cfg.reset_low_ticks  <= ale_pkg::RST_RESET_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ale_pkg::CFG_LED_COUNT:  r_cfg.led_count        <= i_cfg_data[7:0];
                ale_pkg::CFG_ZERO_HIGH:  r_cfg.zero_high_ticks  <= i_cfg_data;
                ale_pkg::CFG_ONE_HIGH:   r_cfg.one_high_ticks   <= i_cfg_data;
                ale_pkg::CFG_BIT_PERIOD: r_cfg.bit_period_ticks <= i_cfg_data;
                ale_pkg::CFG_RESET_LOW:  r_cfg.reset_low_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ale_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_req  (i_start_req),
        .i_mode       (i_mode),
        .i_color      (i_color),
        .i_lit_index  (i_lit_index),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop),
        .o_item       (w_item)
    );

    ale_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item_valid  (w_item_valid),
        .o_item_pop    (w_item_pop),
        .i_item        (w_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line        (o_line),
        .o_busy_res    (o_busy_res),
        .o_pixel_taken (o_pixel_taken),
        .o_done_res    (o_done_res)
    );

endmodule

>>> dv/led_frame_monitor.sv
// ----------------------------------------------------------------------------
// led_frame_monitor
// Watches the tick, result and register channels of the LED frame encoder,
// predicts the line level, busy, pixel-taken and done flags of every accepted
// tick, and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module led_frame_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_start_req,
    input  logic [1:0]                      i_mode,
    input  logic [23:0]                     i_color,
    input  logic [7:0]                      i_lit_index,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_line,
    input  logic                            i_busy_res,
    input  logic                            i_pixel_taken,
    input  logic                            i_done_res,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ale_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ale_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_BIT, SEQ_LATCH} t_seq_phase;

    typedef struct packed {
        logic line;
        logic busy;
        logic taken;
        logic done;
    } t_line_tick;

    ale_pkg::t_cfg regs;
    t_seq_phase    seq;
    logic [1:0]    frame_mode;
    logic [7:0]    led_pos;
    logic [7:0]    target_led;
    logic [23:0]   held_color;
    logic [23:0]   shifter;
    logic [4:0]    bit_pos;
    logic [15:0]   tick_cnt;
    t_line_tick    ticks_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Colour word of the LED at led_pos, already in wire byte order.
    function automatic logic [23:0] led_word(input logic [23:0] in_color);
        logic [23:0] c;
        c = (frame_mode == ale_pkg::MODE_STREAM) ? in_color : held_color;
        if (frame_mode == ale_pkg::MODE_SINGLE && led_pos != target_led) begin
            return '0;
        end
        return {c[15:8], c[23:16], c[7:0]};
    endfunction

    // Advances the predicted sequencer by one tick and returns its outputs.
    function automatic t_line_tick next_line_tick(input ale_pkg::t_item tick_in);
        t_line_tick r;
        logic       data_bit;
        int         high_ticks;
        r = '0;
        if (seq == SEQ_IDLE && tick_in.start_req) begin
            frame_mode = (tick_in.mode == ale_pkg::MODE_UNUSED) ? ale_pkg::MODE_SAME
                                                                : tick_in.mode;
            target_led = tick_in.lit_index;
            held_color = tick_in.color;
            led_pos    = '0;
            bit_pos    = '0;
            tick_cnt   = '0;
            r.busy     = 1'b1;
            if (regs.led_count == 0) begin
                seq = SEQ_LATCH;
            end else begin
                shifter = led_word(tick_in.color);
                r.taken = (frame_mode == ale_pkg::MODE_STREAM);
                seq     = SEQ_BIT;
            end
        end

        // The start tick is also the first tick of the first bit.
        if (seq == SEQ_BIT) begin
            r.busy     = 1'b1;
            data_bit   = (bit_pos < 5'd24) ? shifter[5'd23 - bit_pos] : 1'b0;
            high_ticks = data_bit ? int'(regs.one_high_ticks) : int'(regs.zero_high_ticks);
            r.line     = (int'(tick_cnt) < high_ticks);
            if (int'(tick_cnt) + 1 >= int'(regs.bit_period_ticks)) begin
                tick_cnt = '0;
                if (int'(bit_pos) + 1 >= ale_pkg::COLOR_BITS) begin
                    bit_pos = '0;
                    if (int'(led_pos) + 1 >= int'(regs.led_count)) begin
                        seq = SEQ_LATCH;
                    end else begin
                        led_pos = led_pos + 8'd1;
                        shifter = led_word(tick_in.color);
                        r.taken = (frame_mode == ale_pkg::MODE_STREAM);
                    end
                end else begin
                    bit_pos = bit_pos + 5'd1;
                end
            end else begin
                tick_cnt = tick_cnt + 16'd1;
            end
        end else if (seq == SEQ_LATCH) begin
            r.busy = 1'b1;
            if (int'(tick_cnt) + 1 >= int'(regs.reset_low_ticks)) begin
                r.done   = 1'b1;
                tick_cnt = '0;
                seq      = SEQ_IDLE;
            end else begin
                tick_cnt = tick_cnt + 16'd1;
            end
        end
        return r;
    endfunction

    task automatic log_failure(input string what);
        if (o_fail_count < REPORT_LIMIT) begin
            $display("[%0t] %s", $time, what);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_line_tick got;
        t_line_tick want;
        if (!i_rst_n) begin
            regs       = '{led_count: ale_pkg::RST_LED_COUNT,
                           zero_high_ticks: ale_pkg::RST_ZERO_HIGH,
                           one_high_ticks: ale_pkg::RST_ONE_HIGH,
                           bit_period_ticks: ale_pkg::RST_BIT_PERIOD,
                           reset_low_ticks: ale_pkg::RST_RESET_LOW};
            seq        = SEQ_IDLE;
            frame_mode = ale_pkg::MODE_SAME;
            led_pos    = '0;
            target_led = '0;
            held_color = '0;
            shifter    = '0;
            bit_pos    = '0;
            tick_cnt   = '0;
            ticks_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    ale_pkg::CFG_LED_COUNT:  regs.led_count        = i_cfg_data[7:0];
                    ale_pkg::CFG_ZERO_HIGH:  regs.zero_high_ticks  = i_cfg_data;
                    ale_pkg::CFG_ONE_HIGH:   regs.one_high_ticks   = i_cfg_data;
                    ale_pkg::CFG_BIT_PERIOD: regs.bit_period_ticks = i_cfg_data;
                    ale_pkg::CFG_RESET_LOW:  regs.reset_low_ticks  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                ticks_due.push_back(next_line_tick('{start_req: i_start_req, mode: i_mode,
                                                     color: i_color, lit_index: i_lit_index}));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{line: i_line, busy: i_busy_res, taken: i_pixel_taken,
                        done: i_done_res};
                if (ticks_due.size() == 0) begin
                    log_failure($sformatf("unexpected result line=%0b busy=%0b taken=%0b done=%0b",
                                          got.line, got.busy, got.taken, got.done));
                end else begin
                    want = ticks_due.pop_front();
                    if (got.line !== want.line || got.busy !== want.busy ||
                        got.taken !== want.taken || got.done !== want.done) begin
                        log_failure($sformatf({"mismatch: expected line=%0b busy=%0b ",
                                               "taken=%0b done=%0b, got line=%0b busy=%0b ",
                                               "taken=%0b done=%0b"},
                                              want.line, want.busy, want.taken, want.done,
                                              got.line, got.busy, got.taken, got.done));
                    end
                end
            end
        end
        o_pending = ticks_due.size();
    end

endmodule

>>> dv/tb_addressable_led_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_encoder
// Drives clock ticks into the LED frame encoder under a series of timing
// settings, from degenerate (zero LEDs, zero periods) to the register maximums,
// with random stalls on both sides. A separate monitor predicts and checks.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                              IDLE_PCT       = 17;
    localparam int                              WATCHDOG_LIMIT = 2000;
    localparam int                              SETTLE_CYCLES  = 10;
    localparam logic [ale_pkg::CFG_INDEX_W-1:0] CFG_NO_REG     = 3'd7;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic                            start_req   = 1'b0;
    logic [1:0]                      mode        = ale_pkg::MODE_SAME;
    logic [23:0]                     color       = '0;
    logic [7:0]                      lit_index   = '0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic                            line;
    logic                            busy_res;
    logic                            pixel_taken;
    logic                            done_res;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [ale_pkg::CFG_INDEX_W-1:0] cfg_index   = ale_pkg::CFG_LED_COUNT;
    logic [ale_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending;
    int stalled_cycles = 0;
    bit calm = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    addressable_led_frame_encoder DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_start_req   (start_req),
        .i_mode        (mode),
        .i_color       (color),
        .i_lit_index   (lit_index),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_line        (line),
        .o_busy_res    (busy_res),
        .o_pixel_taken (pixel_taken),
        .o_done_res    (done_res),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    led_frame_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_start_req   (start_req),
        .i_mode        (mode),
        .i_color       (color),
        .i_lit_index   (lit_index),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_line        (line),
        .i_busy_res    (busy_res),
        .i_pixel_taken (pixel_taken),
        .i_done_res    (done_res),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_addressable_led_frame_encoder NOT OK");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_tick(input logic s, input logic [1:0] m, input logic [23:0] c,
                             input logic [7:0] li);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= s;
        mode      <= m;
        color     <= c;
        lit_index <= li;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ale_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ale_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers change only once every tick sent so far has its result back.
    // The sequencer itself may still be in the middle of a frame.
    task automatic program_timing(input int leds, input int zero_hi, input int one_hi,
                                  input int period, input int latch);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(CFG_NO_REG, 16'($urandom));
        write_reg(ale_pkg::CFG_LED_COUNT, {8'($urandom), 8'(leds)});
        write_reg(ale_pkg::CFG_ZERO_HIGH, 16'(zero_hi));
        write_reg(ale_pkg::CFG_ONE_HIGH, 16'(one_hi));
        write_reg(ale_pkg::CFG_BIT_PERIOD, 16'(period));
        write_reg(ale_pkg::CFG_RESET_LOW, 16'(latch));
        cfg_valid <= 1'b0;
    endtask

    // Starts are ignored while a frame runs, so most ticks carry random
    // content into a frame already in progress.
    task automatic run_ticks(input int n);
        logic [7:0] li;
        repeat (n) begin
            li = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
            send_tick($urandom_range(3) == 0, 2'($urandom_range(3)), 24'($urandom), li);
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // The line must stay low while idle under the reset settings.
        send_tick(1'b0, ale_pkg::MODE_SAME, 24'hFFFFFF, 8'hFF);
        send_tick(1'b0, ale_pkg::MODE_UNUSED, 24'h000000, 8'h00);

        // With no LEDs and a zero latch length a start is busy and done at once.
        program_timing(0, 0, 1, 1, 0);
        send_tick(1'b1, ale_pkg::MODE_SAME, 24'hFFFFFF, 8'h00);
        send_tick(1'b1, ale_pkg::MODE_SINGLE, 24'h000000, 8'hFF);
        send_tick(1'b0, ale_pkg::MODE_SAME, 24'h000000, 8'h00);
        send_tick(1'b1, ale_pkg::MODE_STREAM, 24'hA5C33C, 8'h01);
        send_tick(1'b1, ale_pkg::MODE_UNUSED, 24'h5A3CC3, 8'hFE);

        // One tick per bit with a zero high time: the line shows the data bits.
        program_timing(1, 0, 1, 1, 1);
        run_ticks(80);

        calm = 1'b1;
        program_timing(2, 1, 2, 3, 2);
        run_ticks(80);
        calm = 1'b0;

        // High time above the bit period, longest latch.
        program_timing(3, 2, 65535, 2, 65535);
        run_ticks(40);

        // Zero bit period, most LEDs, extreme high times.
        program_timing(255, 65535, 0, 0, 3);
        run_ticks(80);

        // LED count lowered below the position reached in the running frame.
        program_timing(1, 1, 1, 1, 4);
        run_ticks(60);

        program_timing(0, 1, 1, 2, 0);
        run_ticks(30);

        program_timing(3, 0, 1, 1, 1);
        run_ticks(60);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_addressable_led_frame_encoder OK");
        end else begin
            $display("tb_addressable_led_frame_encoder NOT OK");
        end
        $finish;
    end

endmodule
